// ===== hdl/btmt_pkg.sv =====
// Package for the beat tempo median tracker.
// Field widths, interval limits, the tempo numerator and the cell command type.
// No dependencies.
package btmt_pkg;

	localparam int TIME_W            = 32;
	localparam int IBI_W             = 11;
	localparam int TEMPO_W           = 16;
	localparam int MAX_INTERVALS_DEF = 8;

	localparam logic [TIME_W-1:0] IBI_MIN = 32'd300;
	localparam logic [TIME_W-1:0] IBI_MAX = 32'd1200;

	localparam int MIN_FOR_MEDIAN = 3;
	localparam logic [IBI_W-1:0] MEDIAN_FLOOR = 11'd50;

	// 60000 * 256
	localparam int NUM_W = 24;
	localparam logic [NUM_W-1:0] TEMPO_NUM = 24'd15360000;

	typedef struct packed {
		logic del;
		logic ins;
	} cell_op_t;

endpackage

// ===== hdl/btmt_cell.sv =====
// One cell of the sorted interval chain: value, age and valid flag.
// Drops the oldest entry (shift down) or inserts a new one (shift up) from its neighbors.
// Depends on btmt_pkg.
module btmt_cell #(
	parameter int MAX_INTERVALS = btmt_pkg::MAX_INTERVALS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  btmt_pkg::cell_op_t                  op,
	input  logic [btmt_pkg::IBI_W-1:0]          new_val,
	input  logic                                lo_valid,
	input  logic [$clog2(MAX_INTERVALS)-1:0]    lo_age,
	input  logic [btmt_pkg::IBI_W-1:0]          lo_val,
	input  logic                                lo_gt,
	input  logic                                hi_valid,
	input  logic [$clog2(MAX_INTERVALS)-1:0]    hi_age,
	input  logic [btmt_pkg::IBI_W-1:0]          hi_val,
	input  logic                                cum_in,
	output logic                                valid,
	output logic [$clog2(MAX_INTERVALS)-1:0]    age,
	output logic [btmt_pkg::IBI_W-1:0]          val,
	output logic                                gt,
	output logic                                cum_out
);
	import btmt_pkg::*;

	localparam int AGE_W = $clog2(MAX_INTERVALS);
	localparam logic [AGE_W-1:0] OLDEST = AGE_W'(MAX_INTERVALS - 1);

	logic             valid_q;
	logic [AGE_W-1:0] age_q;
	logic [IBI_W-1:0] val_q;
	logic             hit;

	// empty cells sort above everything
	assign gt      = !valid_q || (val_q > new_val);
	assign hit     = valid_q && (age_q == OLDEST);
	assign cum_out = cum_in | hit;

	assign valid = valid_q;
	assign age   = age_q;
	assign val   = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.del && cum_out) begin
			valid_q <= hi_valid;
		end else if (op.ins) begin
			if (lo_gt) begin
				valid_q <= lo_valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.del && cum_out) begin
			age_q <= hi_age;
			val_q <= hi_val;
		end else if (op.ins) begin
			if (lo_gt) begin
				age_q <= lo_age + 1'b1;
				val_q <= lo_val;
			end else if (gt) begin
				age_q <= '0;
				val_q <= new_val;
			end else begin
				age_q <= age_q + 1'b1;
			end
		end
	end

endmodule

// ===== hdl/btmt_div.sv =====
// Serial restoring divider: TEMPO_NUM / divisor, one quotient bit per cycle.
// Depends on btmt_pkg.
module btmt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [btmt_pkg::IBI_W-1:0]    divisor,
	output logic                          busy,
	output logic                          done,
	output logic [btmt_pkg::TEMPO_W-1:0]  quotient
);
	import btmt_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IBI_W-1:0] dvs_q;
	logic [IBI_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [IBI_W:0]   shifted;
	logic [IBI_W+1:0] trial;

	assign shifted = {rem_q, TEMPO_NUM[LAST - cnt_q]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!trial[IBI_W+1]) begin
				rem_q <= trial[IBI_W-1:0];
			end else begin
				rem_q <= shifted[IBI_W-1:0];
			end
			quo_q <= {quo_q[NUM_W-2:0], !trial[IBI_W+1]};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q[TEMPO_W-1:0];

endmodule

// ===== hdl/beat_tempo_median_tracker.sv =====
// Beat tempo median tracker, top level: beat intake, sorted cell chain, median, divider.
// Depends on btmt_pkg, btmt_cell and btmt_div.
//
// Each input item is a beat time in ms. Intervals of 300..1200 ms to the previous beat are
// kept in a chain of MAX_INTERVALS cells sorted by value, each tagged with its age; when the
// chain is full the oldest is dropped before the new one is inserted. With three or more held,
// the median is picked from the middle cells and the tempo 15360000/median (Q8 bpm) comes from
// a serial divider. One result item per input item. An item whose interval is stored and
// yields a median goes through the 24-step divider; an item whose interval is dropped goes
// straight to the output, one with fewer than three stored intervals via the insert step.
// The next item is taken while the previous result waits at the output.
module beat_tempo_median_tracker #(
	parameter int MAX_INTERVALS = btmt_pkg::MAX_INTERVALS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] beat_time_ms
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [0] interval_accepted, [11:1] median_interval_ms,
	                              // [27:12] tempo_q8, [28] tempo_valid, [31:29] zero
);
	import btmt_pkg::*;

	localparam int AGE_W = $clog2(MAX_INTERVALS);
	localparam int IDX_W = $clog2(MAX_INTERVALS);
	localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_INTERVALS);
	localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_FOR_MEDIAN);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DEL  = 6'b000010,
		ST_INS  = 6'b000100,
		ST_MED  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [TIME_W-1:0]   prev_q;
	logic [IBI_W-1:0]    ibi_q;
	logic                acc_q;
	logic [CNT_W-1:0]    fill_q;
	logic [IBI_W-1:0]    held_med_q;
	logic [TEMPO_W-1:0]  held_tempo_q;
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;

	logic                in_acc;
	logic [TIME_W-1:0]   ibi;
	logic                in_range;
	cell_op_t            op;

	logic [MAX_INTERVALS-1:0] c_valid;
	logic [MAX_INTERVALS-1:0] c_gt;
	logic [MAX_INTERVALS-1:0] c_cum;
	logic [AGE_W-1:0]         c_age [MAX_INTERVALS];
	logic [IBI_W-1:0]         c_val [MAX_INTERVALS];

	logic [IDX_W-1:0]   mid;
	logic [IBI_W:0]     pair_sum;
	logic [IBI_W-1:0]   med;
	logic               div_start;
	logic               div_busy;
	logic               div_done;
	logic [TEMPO_W-1:0] div_quo;
	logic               out_load;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign ibi      = s_tdata - prev_q;
	assign in_range = (prev_q != '0) && (ibi >= IBI_MIN) && (ibi <= IBI_MAX);

	assign op.del = (state_q == ST_DEL);
	assign op.ins = (state_q == ST_INS);

	for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
		logic             lo_valid;
		logic [AGE_W-1:0] lo_age;
		logic [IBI_W-1:0] lo_val;
		logic             lo_gt;
		logic             hi_valid;
		logic [AGE_W-1:0] hi_age;
		logic [IBI_W-1:0] hi_val;
		logic             cum_in;

		if (i == 0) begin : g_lo_end
			assign lo_valid = 1'b0;
			assign lo_age   = '0;
			assign lo_val   = '0;
			assign lo_gt    = 1'b0;
			assign cum_in   = 1'b0;
		end else begin : g_lo
			assign lo_valid = c_valid[i-1];
			assign lo_age   = c_age[i-1];
			assign lo_val   = c_val[i-1];
			assign lo_gt    = c_gt[i-1];
			assign cum_in   = c_cum[i-1];
		end

		if (i == MAX_INTERVALS - 1) begin : g_hi_end
			assign hi_valid = 1'b0;
			assign hi_age   = '0;
			assign hi_val   = '0;
		end else begin : g_hi
			assign hi_valid = c_valid[i+1];
			assign hi_age   = c_age[i+1];
			assign hi_val   = c_val[i+1];
		end

		btmt_cell #(
			.MAX_INTERVALS (MAX_INTERVALS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.new_val  (ibi_q),
			.lo_valid (lo_valid),
			.lo_age   (lo_age),
			.lo_val   (lo_val),
			.lo_gt    (lo_gt),
			.hi_valid (hi_valid),
			.hi_age   (hi_age),
			.hi_val   (hi_val),
			.cum_in   (cum_in),
			.valid    (c_valid[i]),
			.age      (c_age[i]),
			.val      (c_val[i]),
			.gt       (c_gt[i]),
			.cum_out  (c_cum[i])
		);
	end

	// median from the sorted chain; even count takes the floor mean of the middle pair
	assign mid      = IDX_W'(fill_q >> 1);
	assign pair_sum = {1'b0, c_val[mid - 1'b1]} + {1'b0, c_val[mid]};
	assign med      = fill_q[0] ? c_val[mid] : pair_sum[IBI_W:1];

	assign div_start = (state_q == ST_MED) && (med > MEDIAN_FLOOR);

	btmt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (med),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_q       <= '0;
			acc_q        <= 1'b0;
			fill_q       <= '0;
			held_med_q   <= '0;
			held_tempo_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						prev_q <= s_tdata;
						acc_q  <= in_range;
						if (!in_range) begin
							state_q <= ST_OUT;
						end else if (fill_q == FULL) begin
							state_q <= ST_DEL;
						end else begin
							state_q <= ST_INS;
						end
					end
				end
				ST_DEL: begin
					state_q <= ST_INS;
				end
				ST_INS: begin
					if (fill_q != FULL) begin
						fill_q <= fill_q + 1'b1;
					end
					if (fill_q + 1'b1 >= MIN_CNT || fill_q == FULL) begin
						state_q <= ST_MED;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_MED: begin
					if (div_start) begin
						held_med_q <= med;
						state_q    <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						held_tempo_q <= div_quo;
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ibi_q <= ibi[IBI_W-1:0];
		end
		if (out_load) begin
			m_tdata_q <= {3'b000, (held_med_q != '0), held_tempo_q, held_med_q, acc_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_fill_matches_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(c_valid) == fill_q))
		else $error("cell chain occupancy differs from fill count");

	a_median_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(held_med_q != '0) |-> (held_med_q >= IBI_W'(IBI_MIN) && held_med_q <= IBI_W'(IBI_MAX)))
		else $error("held median outside stored interval range");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("divider busy while taking an item");

	a_tempo_with_median: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && held_med_q != '0) |-> (held_tempo_q != '0))
		else $error("median held without a tempo");

endmodule

// ===== sim/tb_beat_tempo_median_tracker.sv =====
// Testbench for beat_tempo_median_tracker: beat times in, median interval and Q8 tempo out.
// Self-checking against an in-bench tracker model; depends on btmt_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_beat_tempo_median_tracker;

	import btmt_pkg::*;

	localparam int DEPTH = MAX_INTERVALS_DEF;

	typedef struct packed {
		logic               accepted;
		logic [IBI_W-1:0]   median;
		logic [TEMPO_W-1:0] tempo;
		logic               valid;
	} beat_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	beat_tempo_median_tracker #(.MAX_INTERVALS(DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// tracker state
	logic [TIME_W-1:0]  last_beat = '0;
	logic [IBI_W-1:0]   ibi_ring [DEPTH];
	int                 ring_wp = 0;
	int                 ring_cnt = 0;
	logic [IBI_W-1:0]   med_hold = '0;
	logic [TEMPO_W-1:0] tempo_hold = '0;

	logic [31:0]  beat_q [$];
	beat_result_t result_q [$];

	int   mismatches = 0;
	int   n_beats = 0;
	bit   beat_taken = 1'b0;
	bit   calm = 1'b0;
	int   tx_gap = 0;
	bit   tx_idle_on = 1'b1;
	int   rx_gap = 0;
	bit   rx_idle_on = 1'b1;
	int   hold_left = 0;
	bit   hold_done = 1'b0;

	function automatic beat_result_t track_beat(input logic [TIME_W-1:0] now);
		beat_result_t     r;
		logic [31:0]      ibi;
		logic [31:0]      mid;
		logic [IBI_W-1:0] srt [DEPTH];
		logic [IBI_W-1:0] v;
		int               n;
		int               j;
		r = '0;
		if (last_beat != '0) begin
			ibi = now - last_beat;
			if (ibi >= IBI_MIN && ibi <= IBI_MAX) begin
				ibi_ring[ring_wp] = ibi[IBI_W-1:0];
				ring_wp = (ring_wp + 1) % DEPTH;
				if (ring_cnt < DEPTH)
					ring_cnt++;
				r.accepted = 1'b1;
				if (ring_cnt >= MIN_FOR_MEDIAN) begin
					n = ring_cnt;
					for (int i = 0; i < n; i++)
						srt[i] = ibi_ring[i];
					for (int i = 1; i < n; i++) begin
						v = srt[i];
						j = i;
						while (j > 0 && srt[j-1] > v) begin
							srt[j] = srt[j-1];
							j--;
						end
						srt[j] = v;
					end
					if (n % 2 == 1)
						mid = 32'(srt[n/2]);
					else
						mid = (32'(srt[n/2-1]) + 32'(srt[n/2])) / 2;
					if (mid > 32'(MEDIAN_FLOOR)) begin
						med_hold = mid[IBI_W-1:0];
						tempo_hold = TEMPO_W'(32'(TEMPO_NUM) / mid);
					end
				end
			end
		end
		last_beat = now;
		r.median = med_hold;
		r.tempo = tempo_hold;
		r.valid = (med_hold != '0);
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endtask

	// mostly plausible beat trains, some rejects, jumps and zero times
	task automatic queue_beats(input int count);
		logic [31:0] t;
		int          r;
		t = $urandom;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 72)
				t = t + $urandom_range(300, 1200);
			else if (r < 82)
				case ($urandom_range(0, 3))
					0: t = t + 299;
					1: t = t + 300;
					2: t = t + 1200;
					default: t = t + 1201;
				endcase
			else if (r < 90)
				t = t + $urandom_range(0, 299);
			else if (r < 95)
				t = t + $urandom_range(1201, 5000);
			else if (r < 97)
				t = $urandom;
			else if (r < 99)
				t = 32'hFFFF_FFFF - $urandom_range(0, 1500);
			else
				t = '0;
			beat_q.push_back(t);
		end
	endtask

	// sample handshakes, predict, check
	always @(posedge clk) begin
		beat_result_t want;
		beat_taken = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				beat_taken = 1'b1;
				n_beats++;
				result_q.push_back(track_beat(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					note_mismatch("unexpected item", 0, m_tdata);
				end else begin
					want = result_q.pop_front();
					if (m_tdata[0] !== want.accepted)
						note_mismatch("interval_accepted", want.accepted, m_tdata[0]);
					if (m_tdata[11:1] !== want.median)
						note_mismatch("median_interval_ms", want.median, m_tdata[11:1]);
					if (m_tdata[27:12] !== want.tempo)
						note_mismatch("tempo_q8", want.tempo, m_tdata[27:12]);
					if (m_tdata[28] !== want.valid)
						note_mismatch("tempo_valid", want.valid, m_tdata[28]);
				end
			end
		end
	end

	// sender
	always @(negedge clk) begin
		logic        nv;
		logic [31:0] nd;
		nv = s_tvalid;
		nd = s_tdata;
		if (arst_n && (!s_tvalid || beat_taken)) begin
			nv = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (beat_q.size() > 0) begin
				if (!calm && tx_idle_on && $urandom_range(0, 5) == 0) begin
					tx_gap = $urandom_range(1, 7) - 1;
				end else begin
					nv = 1'b1;
					nd = beat_q.pop_front();
				end
			end
		end
		if ($urandom_range(0, 63) == 0)
			tx_idle_on = !tx_idle_on;
		s_tvalid <= nv;
		s_tdata <= nd;
	end

	// receiver, with one long hold-off while the sender keeps going
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (!hold_done && n_beats >= 150) begin
			hold_left = 399;
			hold_done = 1'b1;
			rdy = 1'b0;
		end else if (!calm) begin
			if (rx_gap > 0) begin
				rx_gap--;
				rdy = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(1, 7) - 1;
				rdy = 1'b0;
			end
		end
		if ($urandom_range(0, 63) == 0)
			rx_idle_on = !rx_idle_on;
		m_tready <= rdy;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [31:0] t;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no earlier beat, time zero, rejects at both limits, even count, wrap
		beat_q.push_back(32'd0);
		beat_q.push_back(32'd1000);
		beat_q.push_back(32'd1299);
		beat_q.push_back(32'd1599);
		beat_q.push_back(32'd2799);
		beat_q.push_back(32'd4000);
		beat_q.push_back(32'd4500);
		beat_q.push_back(32'd5200);
		beat_q.push_back(32'hFFFF_FFFF);
		beat_q.push_back(32'h0000_0257);
		beat_q.push_back(32'd0);
		beat_q.push_back(32'd800);
		// fill the ring and overwrite the oldest entries
		t = 32'd800;
		for (int i = 0; i < 10; i++) begin
			case (i)
				0: t = t + 301;
				1: t = t + 1199;
				2: t = t + 333;
				3: t = t + 999;
				4: t = t + 450;
				5: t = t + 1000;
				6: t = t + 777;
				7: t = t + 1200;
				8: t = t + 300;
				default: t = t + 640;
			endcase
			beat_q.push_back(t);
		end
		beat_q.push_back(32'hAAAA_5555);

		queue_beats(420);
		while (beat_q.size() > 0 || s_tvalid || result_q.size() > 0)
			@(posedge clk);

		queue_beats(380);
		while (beat_q.size() > 0 || s_tvalid || result_q.size() > 0)
			@(posedge clk);

		calm = 1'b1;
		queue_beats(100);
		while (beat_q.size() > 0 || s_tvalid || result_q.size() > 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (mismatches == 0 && result_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== beat_tempo_median_tracker.f =====
hdl/btmt_pkg.sv
hdl/btmt_cell.sv
hdl/btmt_div.sv
hdl/beat_tempo_median_tracker.sv
sim/tb_beat_tempo_median_tracker.sv
